FILE: sv/sefr_pkg.sv
// Shared types and constants for the STX/ETX frame receiver.
// Used by sefr_ctrl, sefr_dp and stx_etx_frame_receiver_top; no dependencies.
package sefr_pkg;

    localparam int MaxFrameBytes = 20;
    localparam int ByteW         = 8;
    localparam int LenW          = 5;
    localparam int IdxW          = $clog2(MaxFrameBytes + 1);
    localparam int StoreDepth    = MaxFrameBytes + 1;
    localparam int CfgIdxW       = 1;
    localparam int OutDataW      = 24;

    localparam logic [ByteW-1:0] HeadByte = 8'h02;
    localparam logic [ByteW-1:0] TailByte = 8'h03;
    localparam logic [ByteW-1:0] IdMark   = 8'hF0;
    localparam logic [ByteW-1:0] CmdLimit = 8'h80;

    localparam logic [LenW-1:0] FloorLength = LenW'(4);
    localparam logic [LenW-1:0] CeilLength  = LenW'(MaxFrameBytes);
    localparam logic [LenW-1:0] MinLenReset = LenW'(4);
    localparam logic [LenW-1:0] MaxLenReset = LenW'(20);

    localparam logic [CfgIdxW-1:0] CfgMinLength = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgMaxLength = 1'b1;

    typedef struct packed {
        logic load_len;
        logic load_cmd;
        logic store_body;
        logic take_tail;
        logic clear_rd;
        logic rd_en;
        logic next_rd;
    } t_cmd;

    typedef struct packed {
        logic is_head;
        logic len_ok;
        logic pos_lt_len;
        logic tail_ok;
        logic rd_last;
    } t_status;

endpackage

FILE: sv/stx_etx_frame_receiver_top.sv
// Receives link bytes, parses STX/ETX frames with an XOR check, and streams out
// each accepted frame head through tail. One input byte is taken per cycle
// while a frame is being parsed. When a good tail arrives, input is held off
// and the frame of L+1 bytes is played out, each byte read from the store (S_READ)
// and then presented from the read register (S_SEND) until m_axis_tready; the
// frame store has a single read port. Rejected frames produce no output.
// Top level: depends on sefr_pkg, sefr_ctrl and sefr_dp.
module stx_etx_frame_receiver_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sefr_pkg::CfgIdxW-1:0]       i_cfg_idx,   // 0 min_length, 1 max_length
    input  logic [sefr_pkg::LenW-1:0]          i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [sefr_pkg::ByteW-1:0]         s_axis_tdata,  // [7:0] rx_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] frame_byte, [12:8] byte_index, [20:13] trans_id, [23:21] zero
    output logic [sefr_pkg::OutDataW-1:0]      m_axis_tdata,
    output logic                               m_axis_tlast,  // last_byte
    output logic                               m_axis_tuser   // trans_id_updated
);
    import sefr_pkg::*;

    t_cmd             cmd;
    t_status          status;
    logic [ByteW-1:0] frame_byte, trans_id;
    logic [IdxW-1:0]  byte_index;

    sefr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sefr_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_rx_byte          (s_axis_tdata),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_frame_byte       (frame_byte),
        .o_byte_index       (byte_index),
        .o_last_byte        (m_axis_tlast),
        .o_trans_id         (trans_id),
        .o_trans_id_updated (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OutDataW - 2*ByteW - IdxW){1'b0}}, trans_id, byte_index,
                           frame_byte};

endmodule

FILE: sv/sefr_ctrl.sv
// Frame receiver controller: parse and emit state machine.
// Depends on sefr_pkg; drives sefr_dp through t_cmd, reads t_status.
module sefr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sefr_pkg::t_status i_status,
    output sefr_pkg::t_cmd    o_cmd
);
    import sefr_pkg::*;

    typedef enum logic [5:0] {
        S_HUNT = 6'b000001,
        S_LEN  = 6'b000010,
        S_CMD  = 6'b000100,
        S_BODY = 6'b001000,
        S_READ = 6'b010000,
        S_SEND = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready  = (r_state == S_HUNT) || (r_state == S_LEN) ||
                         (r_state == S_CMD)  || (r_state == S_BODY);
    assign o_out_valid = (r_state == S_SEND);
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_HUNT: begin
                if (accept && i_status.is_head) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                if (accept) begin
                    if (i_status.len_ok) begin
                        o_cmd.load_len = 1'b1;
                        n_state        = S_CMD;
                    end else if (!i_status.is_head) begin
                        n_state = S_HUNT;
                    end
                end
            end
            S_CMD: begin
                if (accept) begin
                    o_cmd.load_cmd = 1'b1;
                    n_state        = S_BODY;
                end
            end
            S_BODY: begin
                if (accept) begin
                    if (i_status.pos_lt_len) begin
                        o_cmd.store_body = 1'b1;
                    end else if (i_status.tail_ok) begin
                        o_cmd.take_tail = 1'b1;
                        o_cmd.clear_rd  = 1'b1;
                        n_state         = S_READ;
                    end else begin
                        n_state = S_HUNT;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_SEND;
            end
            S_SEND: begin
                if (i_out_ready) begin
                    if (i_status.rd_last) begin
                        n_state = S_HUNT;
                    end else begin
                        o_cmd.next_rd = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: sv/sefr_dp.sv
// Frame receiver datapath: length registers, checksum, frame store, ID capture.
// Depends on sefr_pkg; commanded by sefr_ctrl.
module sefr_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sefr_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [sefr_pkg::LenW-1:0]      i_cfg_data,
    input  logic [sefr_pkg::ByteW-1:0]     i_rx_byte,
    input  sefr_pkg::t_cmd                 i_cmd,
    output sefr_pkg::t_status              o_status,
    output logic [sefr_pkg::ByteW-1:0]     o_frame_byte,
    output logic [sefr_pkg::IdxW-1:0]      o_byte_index,
    output logic                           o_last_byte,
    output logic [sefr_pkg::ByteW-1:0]     o_trans_id,
    output logic                           o_trans_id_updated
);
    import sefr_pkg::*;

    logic [LenW-1:0]  r_min_len, r_max_len;
    logic [LenW-1:0]  lo_len, hi_len;
    logic [IdxW-1:0]  r_len, r_pos, r_rd_addr;
    logic [ByteW-1:0] r_xor, r_cmd_byte, r_h1, r_h2, r_h3;
    logic [ByteW-1:0] r_trans_id, r_rd_data;
    logic             r_updated;
    logic [ByteW-1:0] r_store [StoreDepth];
    logic             wr_en, push;
    logic [IdxW-1:0]  wr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MinLenReset;
            r_max_len <= MaxLenReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgMinLength: r_min_len <= i_cfg_data;
                CfgMaxLength: r_max_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign lo_len = (r_min_len < FloorLength) ? FloorLength : r_min_len;
    assign hi_len = (r_max_len < CeilLength) ? r_max_len : CeilLength;

    assign o_status.is_head    = (i_rx_byte == HeadByte);
    assign o_status.len_ok     = (i_rx_byte >= {{(ByteW-LenW){1'b0}}, lo_len}) &&
                                 (i_rx_byte <= {{(ByteW-LenW){1'b0}}, hi_len});
    assign o_status.pos_lt_len = (r_pos < r_len);
    assign o_status.tail_ok    = (r_pos == r_len) && (i_rx_byte == TailByte) &&
                                 (r_xor == '0);
    assign o_status.rd_last    = (r_rd_addr == r_len);

    assign push = i_cmd.load_len || i_cmd.load_cmd || i_cmd.store_body;

    // last three stored bytes; at the tail they sit at len-1, len-2, len-3
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_len) begin
            r_len <= i_rx_byte[IdxW-1:0];
            r_xor <= HeadByte ^ i_rx_byte;
        end else if (i_cmd.load_cmd || i_cmd.store_body) begin
            r_xor <= r_xor ^ i_rx_byte;
        end
        if (i_cmd.load_cmd) begin
            r_cmd_byte <= i_rx_byte;
            r_pos      <= IdxW'(3);
        end else if (i_cmd.store_body) begin
            r_pos <= r_pos + IdxW'(1);
        end
        if (push) begin
            r_h1 <= i_rx_byte;
            r_h2 <= r_h1;
            r_h3 <= r_h2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans_id <= '0;
            r_updated  <= 1'b0;
        end else if (i_cmd.take_tail) begin
            if ((r_cmd_byte < CmdLimit) && (r_h3 == IdMark)) begin
                r_trans_id <= r_h2;
                r_updated  <= 1'b1;
            end else begin
                r_updated <= 1'b0;
            end
        end
    end

    // head and tail are constants, only length through body go to the store
    assign wr_en   = push;
    assign wr_addr = i_cmd.load_len ? IdxW'(1) :
                     i_cmd.load_cmd ? IdxW'(2) : r_pos;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= i_rx_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_store[r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_rd) begin
            r_rd_addr <= '0;
        end else if (i_cmd.next_rd) begin
            r_rd_addr <= r_rd_addr + IdxW'(1);
        end
    end

    assign o_frame_byte       = (r_rd_addr == '0)    ? HeadByte :
                                (r_rd_addr == r_len) ? TailByte : r_rd_data;
    assign o_byte_index       = r_rd_addr;
    assign o_last_byte        = (r_rd_addr == r_len);
    assign o_trans_id         = r_trans_id;
    assign o_trans_id_updated = r_updated;

endmodule
